FILE: rtl/kbs_pkg.sv
// Shared types, constants and helpers for the bracket sequence unranker.
package kbs_pkg;

    localparam int PAIR_W        = 6;
    localparam int RANK_W        = 60;
    localparam int MAX_PAIRS_DEF = 32;

    // Saturation bound for path counts (1e18) and the value stored above it (1e18+1)
    localparam logic [RANK_W-1:0] SAT_LIMIT = 60'hDE0B6B3A7640000;
    localparam logic [RANK_W-1:0] SAT_VALUE = 60'hDE0B6B3A7640001;

    typedef struct packed {
        logic [PAIR_W-1:0] pair_count;
        logic [RANK_W-1:0] rank;
    } kbs_in_t;

    typedef struct packed {
        logic symbol;
        logic not_found;
        logic last;
    } kbs_out_t;

    // Which address the table read port is driven from
    typedef enum logic [1:0] {
        RD_FILL,
        RD_CHK,
        RD_STEP
    } kbs_rd_mode_t;

    // Controller to datapath
    typedef struct packed {
        logic         fill;
        logic         rd_en;
        kbs_rd_mode_t rd_mode;
        logic         load;
        logic         step;
        logic         out_load;
        logic         out_nf;
    } kbs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fill_done;
        logic bad;
        logic last_step;
    } kbs_status_t;

    // Saturating add of two path counts
    function automatic logic [RANK_W-1:0] sat_add(input logic [RANK_W-1:0] a,
                                                  input logic [RANK_W-1:0] b);
        logic [RANK_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, SAT_LIMIT}) ? SAT_VALUE : s[RANK_W-1:0];
    endfunction

endpackage

FILE: rtl/kbs_dp.sv
// Datapath: path count table, fill pass pipeline, rank walk and output register.
module kbs_dp #(
    parameter int MAX_PAIRS = kbs_pkg::MAX_PAIRS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  kbs_pkg::kbs_in_t    in_data,
    input  kbs_pkg::kbs_cmd_t   cmd,
    output kbs_pkg::kbs_status_t status,
    output kbs_pkg::kbs_out_t   out_data
);
    import kbs_pkg::*;

    localparam int STEPS  = 2 * MAX_PAIRS;
    localparam int ROWS   = STEPS + 1;
    localparam int COLS   = STEPS + 2;
    localparam int DEPTH  = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    // Table memory, one write and one registered read per cycle
    logic [RANK_W-1:0] mem [DEPTH];
    logic [RANK_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [RANK_W-1:0] wr_data;
    logic              wr_en;

    // Fill pass: issue counters and data phase pipeline
    logic [ROW_W-1:0]  fill_row_reg, fill_row_next;
    logic [COL_W-1:0]  fill_j_reg, fill_j_next;
    logic              fill_end_reg, fill_end_next;
    logic              fr_valid_reg, fr_valid_next;
    logic [ROW_W-1:0]  fr_row_reg;
    logic [COL_W-1:0]  fr_j_reg;
    logic [RANK_W-1:0] p1_reg, p2_reg;
    logic [RANK_W-1:0] fr_cur;
    logic              fill_issue;

    // Query registers
    logic [RANK_W-1:0] k_reg;
    logic [ROW_W-1:0]  rem_reg;
    logic [COL_W-1:0]  depth_reg;
    logic              bad_n_reg;
    kbs_out_t          out_reg;

    logic              in_bad_n;
    logic [ROW_W-1:0]  in_rows;
    logic              go_open;

    assign in_bad_n = (in_data.pair_count == '0) ||
                      (in_data.pair_count > PAIR_W'(MAX_PAIRS));
    assign in_rows  = in_bad_n ? '0 : ROW_W'({in_data.pair_count, 1'b0});
    assign go_open  = (k_reg <= rdata_reg);

    // Read address select
    always_comb
    begin
        case (cmd.rd_mode)
            RD_FILL:
            begin
                if (fill_row_reg == '0 || fill_j_reg == COL_W'(COLS))
                    rd_addr = '0;
                else
                    rd_addr = ADDR_W'((fill_row_reg - 1'b1) * COLS + fill_j_reg);
            end
            RD_CHK:  rd_addr = ADDR_W'(in_rows * COLS);
            RD_STEP: rd_addr = ADDR_W'((rem_reg - 1'b1) * COLS + depth_reg + 1'b1);
            default: rd_addr = '0;
        endcase
    end

    // Fill issue counters
    assign fill_issue = cmd.fill && !fill_end_reg;

    always_comb
    begin
        fill_row_next = fill_row_reg;
        fill_j_next   = fill_j_reg;
        fill_end_next = fill_end_reg;
        fr_valid_next = fill_issue;
        if (fill_issue)
        begin
            if (fill_j_reg == COL_W'(COLS))
            begin
                fill_j_next = '0;
                if (fill_row_reg == ROW_W'(ROWS - 1))
                    fill_end_next = 1'b1;
                else
                    fill_row_next = fill_row_reg + 1'b1;
            end
            else
            begin
                fill_j_next = fill_j_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_row_reg <= '0;
            fill_j_reg   <= '0;
            fill_end_reg <= 1'b0;
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fill_row_reg <= fill_row_next;
            fill_j_reg   <= fill_j_next;
            fill_end_reg <= fill_end_next;
            fr_valid_reg <= fr_valid_next;
        end
    end

    // Fill data phase: entry d = j-1 gets prev[j] + prev[j-2]
    assign fr_cur  = (fr_j_reg == COL_W'(COLS) || fr_row_reg == '0) ? '0 : rdata_reg;
    assign wr_en   = fr_valid_reg && (fr_j_reg != '0);
    assign wr_addr = ADDR_W'(fr_row_reg * COLS + fr_j_reg - 1'b1);

    always_comb
    begin
        if (fr_row_reg == '0)
            wr_data = (fr_j_reg == COL_W'(1)) ? RANK_W'(1) : '0;
        else
            wr_data = sat_add(fr_cur, p2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (fill_issue)
        begin
            fr_row_reg <= fill_row_reg;
            fr_j_reg   <= fill_j_reg;
        end
        if (fr_valid_reg)
        begin
            p1_reg <= fr_cur;
            p2_reg <= (fr_j_reg == '0) ? '0 : p1_reg;
        end
    end

    // Table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Query capture and rank walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            k_reg     <= in_data.rank;
            rem_reg   <= in_rows;
            depth_reg <= '0;
            bad_n_reg <= in_bad_n;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_reg - 1'b1;
            if (go_open)
            begin
                depth_reg <= depth_reg + 1'b1;
            end
            else
            begin
                k_reg <= k_reg - rdata_reg;
                if (depth_reg != '0)
                    depth_reg <= depth_reg - 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_nf)
            begin
                out_reg.symbol    <= 1'b0;
                out_reg.not_found <= 1'b1;
                out_reg.last      <= 1'b1;
            end
            else
            begin
                out_reg.symbol    <= !go_open;
                out_reg.not_found <= 1'b0;
                out_reg.last      <= (rem_reg == ROW_W'(1));
            end
        end
    end

    assign out_data         = out_reg;
    assign status.fill_done = fill_end_reg && !fr_valid_reg;
    assign status.bad       = bad_n_reg || (k_reg == '0) || (k_reg > rdata_reg);
    assign status.last_step = (rem_reg == ROW_W'(1));

endmodule

FILE: rtl/kbs_ctrl.sv
// Controller: sequences the fill pass, the range check and the per-symbol walk.
module kbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  kbs_pkg::kbs_status_t status,
    output kbs_pkg::kbs_cmd_t    cmd
);
    import kbs_pkg::*;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_CHK,
        S_STEP_RD,
        S_STEP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_mode = RD_STEP;
        in_ready    = 1'b0;
        case (state_reg)
            S_FILL:
            begin
                cmd.fill    = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = RD_FILL;
                if (status.fill_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = RD_CHK;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (status.bad)
                begin
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_nf   = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (out_free)
                begin
                    cmd.step     = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = status.last_step ? S_IDLE : S_STEP_RD;
                end
            end
            S_STEP_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_STEP;
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/kth_balanced_bracket_sequence.sv
// Top level: k-th balanced bracket sequence generator (Dyck word unranking).
//
//  channel  direction  handshake             payload
//  in       input      in_valid/in_ready     in_data  (pair_count, rank)
//  out      output     out_valid/out_ready   out_data (symbol, not_found, last)
//
//  After reset the path count table is built in one pass; no request is taken meanwhile.
//  A request with n pairs takes one table read and one decision per symbol; every read
//  goes through the single read port of the table memory. A not-found request ends in the
//  range check with one not-found result, which also carries the last mark.
//  A full output register stalls the walk; the next request is taken once the last
//  symbol sits in the output register.
module kth_balanced_bracket_sequence #(
    parameter int MAX_PAIRS = kbs_pkg::MAX_PAIRS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kbs_pkg::kbs_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output kbs_pkg::kbs_out_t out_data
);
    import kbs_pkg::*;

    kbs_cmd_t    cmd;
    kbs_status_t status;

    kbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    kbs_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

    // A pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result overwritten before being taken");

    // One request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while busy");

    // No request taken during the fill pass
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> !in_ready)
        else $error("request taken during table fill");

    // A not-found result always ends its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.not_found) |-> out_data.last)
        else $error("not-found result without last mark");

endmodule
